FILE: hdl/sbce_pkg.sv
package sbce_pkg;

  localparam int LogitW  = 16;
  localparam int TargetW = 16;
  localparam int LossW   = 17;
  localparam int PointW  = 16;

  localparam logic signed [LossW-1:0] LossMax = 17'sd65535;
  localparam logic signed [LossW-1:0] LossMin = -17'sd65536;

  localparam longint unsigned FxOne = 64'd1 << 30;

  // Control bits that travel alongside the data in every stage.
  typedef struct packed {
    logic vld;
    logic last;
    logic ign;
  } sbce_ctrl_t;

  // Shift-subtract division, used only when the table constants are built.
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1+y) in Q30 via 2*atanh(y/(2+y)), odd terms up to 39.
  function automatic longint unsigned ln1p_q30(longint unsigned y);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    z   = udiv(y << 30, 2 * FxOne + y);
    z2  = (z * z) >> 30;
    p   = z;
    acc = '0;
    for (int unsigned k = 1; k <= 39; k += 2) begin
      acc = acc + udiv(p, 64'(k));
      p   = (p * z2) >> 30;
    end
    return 2 * acc;
  endfunction

  // exp(-16/n) in Q30 from a Taylor series through the 24th-order term.
  function automatic longint unsigned exp_step_q30(int unsigned n);
    longint unsigned h;
    longint unsigned term;
    longint          sum;
    h    = udiv(64'd16 << 30, 64'(n));
    term = FxOne;
    sum  = longint'(FxOne);
    for (int unsigned k = 1; k <= 24; k++) begin
      term = udiv((term * h) >> 30, 64'(k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return longint'(sum);
  endfunction

  // Table point i: ln(1+exp(-16*i/n)) in unsigned Q0.16.
  function automatic longint unsigned sp_point(int unsigned n, int unsigned i);
    longint unsigned dec;
    longint unsigned e;
    dec = exp_step_q30(n);
    e   = FxOne;
    for (int unsigned j = 0; j < i; j++) begin
      e = (e * dec + (64'd1 << 29)) >> 30;
    end
    return (ln1p_q30(e) + (64'd1 << 13)) >> 14;
  endfunction

endpackage

FILE: hdl/sbce_in_if.sv
interface sbce_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbce_pkg::LogitW-1:0]   logit_value;
  logic signed [sbce_pkg::TargetW-1:0]  target_value;
  logic                                 last_in;

  modport source (output valid, logit_value, target_value, last_in, input ready);
  modport sink   (input valid, logit_value, target_value, last_in, output ready);
endinterface

FILE: hdl/sbce_out_if.sv
interface sbce_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sbce_pkg::LossW-1:0]  loss_value;
  logic                               valid_flag;
  logic                               last_out;

  modport source (output valid, loss_value, valid_flag, last_out, input ready);
  modport sink   (input valid, loss_value, valid_flag, last_out, output ready);
endinterface

FILE: hdl/sbce_lookup.sv
// Stage 1: |x|, table position, softplus point and slope, and (step - t).
module sbce_lookup #(
  parameter int LOGIT_FRAC_BITS        = 11,
  parameter int TARGET_FRAC_BITS       = 14,
  parameter int SOFTPLUS_TABLE_ENTRIES = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic                                  last_i,
  input  logic signed [sbce_pkg::LogitW-1:0]    logit_i,
  input  logic signed [sbce_pkg::TargetW-1:0]   target_i,
  output sbce_pkg::sbce_ctrl_t                  ctrl_o,
  output logic [sbce_pkg::PointW-1:0]           sp_o,
  output logic signed [sbce_pkg::PointW:0]      d_o,
  output logic [LOGIT_FRAC_BITS+3:0]            fr_o,
  output logic signed [sbce_pkg::LogitW-1:0]    x_o,
  output logic signed [((TARGET_FRAC_BITS+2 > 17) ? TARGET_FRAC_BITS+2 : 17)-1:0] sm_o
);

  localparam int SpanW = LOGIT_FRAC_BITS + 4;
  localparam int SmW   = (TARGET_FRAC_BITS + 2 > 17) ? TARGET_FRAC_BITS + 2 : 17;
  localparam int TabW  = $clog2(SOFTPLUS_TABLE_ENTRIES + 1);
  localparam int IdxTW = $clog2(SOFTPLUS_TABLE_ENTRIES);
  localparam int PosW0 = sbce_pkg::LogitW + TabW;
  localparam int PosW  = (PosW0 > SpanW + 1) ? PosW0 : SpanW + 1;
  localparam int PtW   = sbce_pkg::PointW;

  localparam logic [PosW-1:0] NPos = PosW'(SOFTPLUS_TABLE_ENTRIES);
  localparam logic [PtW-1:0]  SpLast =
    PtW'(sbce_pkg::sp_point(SOFTPLUS_TABLE_ENTRIES, SOFTPLUS_TABLE_ENTRIES));
  localparam logic signed [SmW-1:0] StepOne = SmW'(64'd1 << TARGET_FRAC_BITS);

  logic [PtW-1:0]        sp_tab [SOFTPLUS_TABLE_ENTRIES];
  logic signed [PtW:0]   d_tab  [SOFTPLUS_TABLE_ENTRIES];

  for (genvar g = 0; g < SOFTPLUS_TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [PtW-1:0] Pt     = PtW'(sbce_pkg::sp_point(SOFTPLUS_TABLE_ENTRIES, g));
    localparam logic [PtW-1:0] PtNext = PtW'(sbce_pkg::sp_point(SOFTPLUS_TABLE_ENTRIES, g + 1));
    assign sp_tab[g] = Pt;
    assign d_tab[g]  = $signed({1'b0, Pt}) - $signed({1'b0, PtNext});
  end

  logic [sbce_pkg::LogitW-1:0] mag_x;
  logic [PosW-1:0]             pos;
  logic [PosW-1:0]             idx_ext;
  logic                        clamp;

  sbce_pkg::sbce_ctrl_t        ctrl_d, ctrl_q;
  logic [PtW-1:0]              sp_d, sp_q;
  logic signed [PtW:0]         d_d, d_q;
  logic [SpanW-1:0]            fr_d, fr_q;
  logic signed [SmW-1:0]       sm_d, sm_q;
  logic signed [sbce_pkg::LogitW-1:0] x_q;

  always_comb begin
    mag_x   = logit_i[sbce_pkg::LogitW-1] ? (~logit_i + 16'd1) : logit_i;
    pos     = PosW'(mag_x) * NPos;
    idx_ext = pos >> SpanW;
    clamp   = (idx_ext >= NPos);
    fr_d    = pos[SpanW-1:0];
    // past the table domain: last point, zero slope
    sp_d    = clamp ? SpLast : sp_tab[idx_ext[IdxTW-1:0]];
    d_d     = clamp ? '0 : d_tab[idx_ext[IdxTW-1:0]];
    sm_d    = (logit_i[sbce_pkg::LogitW-1] ? '0 : StepOne) - SmW'(target_i);
    ctrl_d.vld  = valid_i;
    ctrl_d.last = last_i;
    ctrl_d.ign  = target_i[sbce_pkg::TargetW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q <= sp_d;
      d_q  <= d_d;
      fr_q <= fr_d;
      sm_q <= sm_d;
      x_q  <= logit_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign sp_o   = sp_q;
  assign d_o    = d_q;
  assign fr_o   = fr_q;
  assign sm_o   = sm_q;
  assign x_o    = x_q;

endmodule

FILE: hdl/sbce_mult.sv
// Stage 2: interpolation product and linear term.
module sbce_mult #(
  parameter int LOGIT_FRAC_BITS  = 11,
  parameter int TARGET_FRAC_BITS = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sbce_pkg::sbce_ctrl_t                  ctrl_i,
  input  logic [sbce_pkg::PointW-1:0]           sp_i,
  input  logic signed [sbce_pkg::PointW:0]      d_i,
  input  logic [LOGIT_FRAC_BITS+3:0]            fr_i,
  input  logic signed [sbce_pkg::LogitW-1:0]    x_i,
  input  logic signed [((TARGET_FRAC_BITS+2 > 17) ? TARGET_FRAC_BITS+2 : 17)-1:0] sm_i,
  output sbce_pkg::sbce_ctrl_t                  ctrl_o,
  output logic [sbce_pkg::PointW-1:0]           sp_o,
  output logic signed [sbce_pkg::PointW+LOGIT_FRAC_BITS+5:0] num_o,
  output logic signed [sbce_pkg::LogitW+((TARGET_FRAC_BITS+2 > 17) ?
                                         TARGET_FRAC_BITS+2 : 17)-1:0] lin_o
);

  localparam int SmW  = (TARGET_FRAC_BITS + 2 > 17) ? TARGET_FRAC_BITS + 2 : 17;
  localparam int NumW = sbce_pkg::PointW + LOGIT_FRAC_BITS + 6;
  localparam int LinW = sbce_pkg::LogitW + SmW;

  sbce_pkg::sbce_ctrl_t        ctrl_q;
  logic [sbce_pkg::PointW-1:0] sp_q;
  logic signed [NumW-1:0]      num_d, num_q;
  logic signed [LinW-1:0]      lin_d, lin_q;

  assign num_d = d_i * $signed({1'b0, fr_i});
  assign lin_d = x_i * sm_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q  <= sp_i;
      num_q <= num_d;
      lin_q <= lin_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign sp_o   = sp_q;
  assign num_o  = num_q;
  assign lin_o  = lin_q;

endmodule

FILE: hdl/sbce_interp.sv
// Stage 3: round the interpolation step and form the softplus value.
module sbce_interp #(
  parameter int LOGIT_FRAC_BITS  = 11,
  parameter int TARGET_FRAC_BITS = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sbce_pkg::sbce_ctrl_t                  ctrl_i,
  input  logic [sbce_pkg::PointW-1:0]           sp_i,
  input  logic signed [sbce_pkg::PointW+LOGIT_FRAC_BITS+5:0] num_i,
  input  logic signed [sbce_pkg::LogitW+((TARGET_FRAC_BITS+2 > 17) ?
                                         TARGET_FRAC_BITS+2 : 17)-1:0] lin_i,
  output sbce_pkg::sbce_ctrl_t                  ctrl_o,
  output logic signed [sbce_pkg::PointW+1:0]    sp_o,
  output logic signed [sbce_pkg::LogitW+((TARGET_FRAC_BITS+2 > 17) ?
                                         TARGET_FRAC_BITS+2 : 17)-1:0] lin_o
);

  localparam int SmW   = (TARGET_FRAC_BITS + 2 > 17) ? TARGET_FRAC_BITS + 2 : 17;
  localparam int SpanW = LOGIT_FRAC_BITS + 4;
  localparam int NumW  = sbce_pkg::PointW + LOGIT_FRAC_BITS + 6;
  localparam int LinW  = sbce_pkg::LogitW + SmW;
  localparam int SpW   = sbce_pkg::PointW + 2;

  localparam logic [NumW-1:0] Half = NumW'(64'd1 << (SpanW - 1));

  sbce_pkg::sbce_ctrl_t   ctrl_q;
  logic [NumW-1:0]        abs_num;
  logic [NumW-1:0]        qm;
  logic signed [SpW-1:0]  sp_d, sp_q;
  logic signed [LinW-1:0] lin_q;

  // round to nearest, ties away from zero
  always_comb begin
    abs_num = num_i[NumW-1] ? unsigned'(-num_i) : unsigned'(num_i);
    qm      = (abs_num + Half) >> SpanW;
    if (num_i[NumW-1]) begin
      sp_d = $signed({2'b00, sp_i}) + $signed(SpW'(qm));
    end else begin
      sp_d = $signed({2'b00, sp_i}) - $signed(SpW'(qm));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q  <= sp_d;
      lin_q <= lin_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign sp_o   = sp_q;
  assign lin_o  = lin_q;

endmodule

FILE: hdl/sbce_combine.sv
// Stages 4 and 5: sum both terms at full precision, then round, saturate
// and hold the result in the output register; ignored elements give zero.
module sbce_combine #(
  parameter int LOGIT_FRAC_BITS  = 11,
  parameter int TARGET_FRAC_BITS = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sbce_pkg::sbce_ctrl_t                  ctrl_i,
  input  logic signed [sbce_pkg::PointW+1:0]    sp_i,
  input  logic signed [sbce_pkg::LogitW+((TARGET_FRAC_BITS+2 > 17) ?
                                         TARGET_FRAC_BITS+2 : 17)-1:0] lin_i,
  output sbce_pkg::sbce_ctrl_t                  ctrl_o,
  output logic signed [sbce_pkg::LossW-1:0]     loss_o
);

  localparam int SmW   = (TARGET_FRAC_BITS + 2 > 17) ? TARGET_FRAC_BITS + 2 : 17;
  localparam int LinW  = sbce_pkg::LogitW + SmW;
  localparam int SpW   = sbce_pkg::PointW + 2;
  localparam int FT    = LOGIT_FRAC_BITS + TARGET_FRAC_BITS;
  localparam int TotW  = ((LinW + 16 > SpW + FT) ? LinW + 16 : SpW + FT) + 1;
  localparam int Sh    = FT + 5;
  localparam int LossW = sbce_pkg::LossW;

  localparam logic [TotW:0] RHalf   = (TotW + 1)'(64'd1 << (Sh - 1));
  localparam logic [TotW:0] LimPos  = (TotW + 1)'(65535);
  localparam logic [TotW:0] LimNeg  = (TotW + 1)'(65536);

  sbce_pkg::sbce_ctrl_t    ctrl4_q, ctrl5_q;
  logic signed [TotW-1:0]  total_d, total_q;
  logic                    neg;
  logic [TotW-1:0]         abs_t;
  logic [TotW:0]           rnd;
  logic signed [LossW-1:0] loss_d, loss_q;

  assign total_d = (TotW'(lin_i) <<< 16) + (TotW'(sp_i) <<< FT);

  always_comb begin
    neg   = total_q[TotW-1];
    abs_t = neg ? unsigned'(-total_q) : unsigned'(total_q);
    rnd   = ({1'b0, abs_t} + RHalf) >> Sh;
    if (ctrl4_q.ign) begin
      loss_d = '0;
    end else if (neg) begin
      loss_d = (rnd > LimNeg) ? sbce_pkg::LossMin : $signed(LossW'(0) - rnd[LossW-1:0]);
    end else begin
      loss_d = (rnd > LimPos) ? sbce_pkg::LossMax : $signed(rnd[LossW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl4_q <= '0;
      ctrl5_q <= '0;
    end else if (en_i) begin
      ctrl4_q <= ctrl_i;
      ctrl5_q <= ctrl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q <= total_d;
      loss_q  <= loss_d;
    end
  end

  assign ctrl_o = ctrl5_q;
  assign loss_o = loss_q;

endmodule

FILE: hdl/sigmoid_bce_loss_with_ignore.sv
// Pipeline: five register stages, lookup, mult, interp and the two of combine.
// Throughput: one item per clock; the stages advance together whenever the output
// register is empty or its result is taken in the same cycle.
// Reset: rst_ni clears every stage valid bit at once; the softplus table is constant
// logic, so items are accepted in the first cycle after reset.
module sigmoid_bce_loss_with_ignore #(
  parameter int LOGIT_FRAC_BITS        = 11,
  parameter int TARGET_FRAC_BITS       = 14,
  parameter int SOFTPLUS_TABLE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbce_in_if.sink    in_i,
  sbce_out_if.source out_o
);

  localparam int SmW   = (TARGET_FRAC_BITS + 2 > 17) ? TARGET_FRAC_BITS + 2 : 17;
  localparam int SpanW = LOGIT_FRAC_BITS + 4;
  localparam int NumW  = sbce_pkg::PointW + LOGIT_FRAC_BITS + 6;
  localparam int LinW  = sbce_pkg::LogitW + SmW;

  logic en;

  sbce_pkg::sbce_ctrl_t s1_ctrl, s2_ctrl, s3_ctrl, out_ctrl;

  logic [sbce_pkg::PointW-1:0]        s1_sp;
  logic signed [sbce_pkg::PointW:0]   s1_d;
  logic [SpanW-1:0]                   s1_fr;
  logic signed [sbce_pkg::LogitW-1:0] s1_x;
  logic signed [SmW-1:0]              s1_sm;

  logic [sbce_pkg::PointW-1:0]        s2_sp;
  logic signed [NumW-1:0]             s2_num;
  logic signed [LinW-1:0]             s2_lin;

  logic signed [sbce_pkg::PointW+1:0] s3_sp;
  logic signed [LinW-1:0]             s3_lin;

  logic signed [sbce_pkg::LossW-1:0]  out_loss;

  assign en         = !out_ctrl.vld || out_o.ready;
  assign in_i.ready = en;

  sbce_lookup #(
    .LOGIT_FRAC_BITS       (LOGIT_FRAC_BITS),
    .TARGET_FRAC_BITS      (TARGET_FRAC_BITS),
    .SOFTPLUS_TABLE_ENTRIES(SOFTPLUS_TABLE_ENTRIES)
  ) u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .last_i  (in_i.last_in),
    .logit_i (in_i.logit_value),
    .target_i(in_i.target_value),
    .ctrl_o  (s1_ctrl),
    .sp_o    (s1_sp),
    .d_o     (s1_d),
    .fr_o    (s1_fr),
    .x_o     (s1_x),
    .sm_o    (s1_sm)
  );

  sbce_mult #(
    .LOGIT_FRAC_BITS (LOGIT_FRAC_BITS),
    .TARGET_FRAC_BITS(TARGET_FRAC_BITS)
  ) u_mult (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(s1_ctrl),
    .sp_i  (s1_sp),
    .d_i   (s1_d),
    .fr_i  (s1_fr),
    .x_i   (s1_x),
    .sm_i  (s1_sm),
    .ctrl_o(s2_ctrl),
    .sp_o  (s2_sp),
    .num_o (s2_num),
    .lin_o (s2_lin)
  );

  sbce_interp #(
    .LOGIT_FRAC_BITS (LOGIT_FRAC_BITS),
    .TARGET_FRAC_BITS(TARGET_FRAC_BITS)
  ) u_interp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(s2_ctrl),
    .sp_i  (s2_sp),
    .num_i (s2_num),
    .lin_i (s2_lin),
    .ctrl_o(s3_ctrl),
    .sp_o  (s3_sp),
    .lin_o (s3_lin)
  );

  sbce_combine #(
    .LOGIT_FRAC_BITS (LOGIT_FRAC_BITS),
    .TARGET_FRAC_BITS(TARGET_FRAC_BITS)
  ) u_combine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(s3_ctrl),
    .sp_i  (s3_sp),
    .lin_i (s3_lin),
    .ctrl_o(out_ctrl),
    .loss_o(out_loss)
  );

  assign out_o.valid      = out_ctrl.vld;
  assign out_o.loss_value = out_loss;
  assign out_o.valid_flag = ~out_ctrl.ign;
  assign out_o.last_out   = out_ctrl.last;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ctrl.vld |-> in_i.ready)
    else $error("input stalled while output register empty");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_ctrl.vld)
    else $error("input transfer lost at first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_ctrl) && $stable(s2_ctrl) && $stable(s3_ctrl)))
    else $error("pipeline moved during a stall");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_ctrl.vld) |=> s3_ctrl.vld)
    else $error("item dropped between stages");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ctrl.vld && out_ctrl.ign) |-> (out_loss == '0))
    else $error("ignored element with nonzero loss");

endmodule
